// File: rtl/core/jlm_pkg.sv
// Package with the types, codes and helper functions of the joint limit merge core.
`default_nettype none

package jlm_pkg;

   localparam int MAX_JOINTS = 16;
   localparam int VALUE_BITS = 32;
   localparam int STAMP_BITS = 32;
   localparam int NKINDS     = 5;
   localparam int NDEFAULTS  = 4;
   localparam int JOINT_BITS = $clog2(MAX_JOINTS);
   localparam int COUNT_BITS = 5;
   localparam int KIND_BITS  = 3;

   localparam logic signed [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

   // Limit kinds, also the merged and time slot of a row.
   localparam logic [KIND_BITS-1:0] KIND_POS_UPPER = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_POS_LOWER = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_VEL_UPPER = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_VEL_LOWER = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_EFFORT    = 3'd4;

   // Default slots of a row.
   localparam int DEF_POS_UPPER = 0;
   localparam int DEF_POS_LOWER = 1;
   localparam int DEF_VELOCITY  = 2;
   localparam int DEF_EFFORT    = 3;

   // Configuration register indexes.
   localparam logic CSR_JOINT_COUNT   = 1'b0;
   localparam logic CSR_TIMEOUT_TICKS = 1'b1;

   localparam logic [STAMP_BITS-1:0] TIMEOUT_RESET = 32'd100000;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_OFFER = 2'd1,
      CMD_TICK  = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TICK_RD,
      ST_TICK_EMIT
   } state_type;

   typedef logic signed [VALUE_BITS-1:0] value_type;

   // One memory row holds everything known about one joint.
   typedef struct packed {
      logic [NKINDS-1:0][STAMP_BITS-1:0] times;
      logic [NKINDS-1:0][VALUE_BITS-1:0] merged;
      logic [NDEFAULTS-1:0][VALUE_BITS-1:0] defaults;
   } row_type;

   function automatic value_type negate_sat(input value_type v);
      return (v == VALUE_MIN) ? VALUE_MAX : -v;
   endfunction

   // Lower kinds tighten upward, all others tighten downward.
   function automatic logic is_tightening(input logic [KIND_BITS-1:0] kind,
                                          input value_type cur, input value_type inc);
      if (kind == KIND_POS_LOWER || kind == KIND_VEL_LOWER) begin
         return inc > cur;
      end
      return inc < cur;
   endfunction

   // For a negative difference d, |d| <= t is the same as ~d < t.
   function automatic logic is_recent(input logic [STAMP_BITS-1:0] now,
                                      input logic [STAMP_BITS-1:0] then_t,
                                      input logic [STAMP_BITS-1:0] timeout);
      logic [STAMP_BITS-1:0] d;
      d = now - then_t;
      if (d[STAMP_BITS-1]) begin
         return (~d) < timeout;
      end
      return d <= timeout;
   endfunction

   function automatic value_type default_for(
      input logic [NDEFAULTS-1:0][VALUE_BITS-1:0] defs, input logic [KIND_BITS-1:0] kind);
      value_type res;
      case (kind)
         KIND_POS_UPPER: res = defs[DEF_POS_UPPER];
         KIND_POS_LOWER: res = defs[DEF_POS_LOWER];
         KIND_VEL_UPPER: res = defs[DEF_VELOCITY];
         KIND_VEL_LOWER: res = negate_sat(defs[DEF_VELOCITY]);
         default:        res = defs[DEF_EFFORT];
      endcase
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/joint_limit_merge_with_timeout_core.sv
// Joint limit merge core: per-joint default and merged limits with staleness timeout.
// A load or offer reads its row in the cycle it is accepted, then modifies and writes it back
// in EXEC; the core takes no new request until that write back is done.
// A tick walks the joints in use (joint_count capped at 16), one row read and one
// row write per joint; its first word is registered after the EXEC and TICK_RD states,
// and each word waits while the result register is still held by the consumer.
// Reset: synchronous, active high; clears control, row valid bits, timeout_ticks to 100000.
`default_nettype none

module joint_limit_merge_with_timeout_core (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic        req_tvalid,
   output      logic        req_tready,
   // joint [3:0], value [35:4], stamp [67:36], zero fill [71:68]
   input  wire logic [71:0] req_tdata,
   // command [1:0], kind [4:2]
   input  wire logic [4:0]  req_tuser,

   output      logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   // joint_index [3:0], pos_upper [35:4], pos_lower [67:36], vel_upper [99:68],
   // vel_lower [131:100], effort_max [163:132], zero fill [167:164]
   output      logic [167:0] rsp_tdata,
   output      logic         rsp_tlast,

   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import jlm_pkg::*;

   localparam int RSP_BITS = 168;

   state_type state_ff, state_in;

   logic [COUNT_BITS-1:0] joint_count_ff;
   logic [STAMP_BITS-1:0] timeout_ff;

   cmd_type               cmd_ff;
   logic [JOINT_BITS-1:0] joint_ff;
   logic [KIND_BITS-1:0]  kind_ff;
   value_type             value_ff;
   logic [STAMP_BITS-1:0] stamp_ff;

   logic [JOINT_BITS-1:0] idx_ff, idx_in;

   row_type               mem [MAX_JOINTS];
   row_type               rd_row_ff;
   logic                  rd_valid_ff;
   logic [MAX_JOINTS-1:0] row_valid_ff;

   logic                  mem_re, mem_we;
   logic [JOINT_BITS-1:0] rd_addr, wr_addr;
   row_type               wr_row, item_row, tick_row, row_cur;

   logic                  accept, out_free, load_out, tick_last;
   logic [COUNT_BITS-1:0] n_joints;

   logic                  rsp_valid_ff;
   logic [RSP_BITS-1:0]   rsp_data_ff, rsp_data_in;
   logic                  rsp_last_ff;

   value_type [NKINDS-1:0] publish;

   assign accept    = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign n_joints  = (joint_count_ff > COUNT_BITS'(MAX_JOINTS)) ? COUNT_BITS'(MAX_JOINTS)
                                                                  : joint_count_ff;
   assign tick_last = ({1'b0, idx_ff} + COUNT_BITS'(1)) == n_joints;
   assign csr_ready = 1'b1;

   // Next state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            idx_in = '0;
            if (cmd_ff == CMD_TICK && n_joints != '0) begin
               state_in = ST_TICK_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_TICK_RD: begin
            state_in = ST_TICK_EMIT;
         end
         ST_TICK_EMIT: begin
            if (out_free) begin
               if (tick_last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_TICK_RD;
                  idx_in   = idx_ff + JOINT_BITS'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      req_tready = 1'b0;
      mem_re     = 1'b0;
      mem_we     = 1'b0;
      load_out   = 1'b0;
      rd_addr    = idx_ff;
      wr_addr    = joint_ff;
      wr_row     = item_row;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            mem_re     = req_tvalid;
            rd_addr    = req_tdata[JOINT_BITS-1:0];
         end
         ST_EXEC: begin
            mem_we = (cmd_ff == CMD_LOAD) || (cmd_ff == CMD_OFFER);
         end
         ST_TICK_RD: begin
            mem_re = 1'b1;
         end
         ST_TICK_EMIT: begin
            mem_we   = out_free;
            load_out = out_free;
            wr_addr  = idx_ff;
            wr_row   = tick_row;
         end
         default: ;
      endcase
   end

   // Row modification for load, offer and tick.
   always_comb begin
      value_type def_v, mrg_v;
      logic      recent;
      row_cur = rd_row_ff;
      if (!rd_valid_ff) begin
         row_cur.times = '0;
      end
      item_row = row_cur;
      tick_row = row_cur;
      for (int k = 0; k < NKINDS; k++) begin
         def_v  = default_for(row_cur.defaults, KIND_BITS'(k));
         mrg_v  = row_cur.merged[k];
         recent = is_recent(stamp_ff, row_cur.times[k], timeout_ff);
         publish[k] = (recent && is_tightening(KIND_BITS'(k), def_v, mrg_v)) ? mrg_v : def_v;
         if (!recent) begin
            tick_row.merged[k] = def_v;
         end
      end
      case (cmd_ff)
         CMD_LOAD: begin
            case (kind_ff)
               KIND_POS_UPPER: begin
                  item_row.defaults[DEF_POS_UPPER] = value_ff;
                  item_row.merged[KIND_POS_UPPER]  = value_ff;
               end
               KIND_POS_LOWER: begin
                  item_row.defaults[DEF_POS_LOWER] = value_ff;
                  item_row.merged[KIND_POS_LOWER]  = value_ff;
               end
               KIND_VEL_UPPER: begin
                  item_row.defaults[DEF_VELOCITY]  = value_ff;
                  item_row.merged[KIND_VEL_UPPER]  = value_ff;
                  item_row.merged[KIND_VEL_LOWER]  = negate_sat(value_ff);
               end
               KIND_EFFORT: begin
                  item_row.defaults[DEF_EFFORT]    = value_ff;
                  item_row.merged[KIND_EFFORT]     = value_ff;
               end
               default: ;
            endcase
         end
         CMD_OFFER: begin
            if ({1'b0, joint_ff} < joint_count_ff && kind_ff < KIND_BITS'(NKINDS)
                && is_tightening(kind_ff, row_cur.merged[kind_ff], value_ff)) begin
               item_row.merged[kind_ff] = value_ff;
               item_row.times[kind_ff]  = stamp_ff;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[JOINT_BITS-1:0] = idx_ff;
      for (int k = 0; k < NKINDS; k++) begin
         rsp_data_in[JOINT_BITS + k*VALUE_BITS +: VALUE_BITS] = publish[k];
      end
   end

   // Row memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_row;
      end
      if (mem_re) begin
         rd_row_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idx_ff         <= '0;
         row_valid_ff   <= '0;
         rd_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         rsp_last_ff    <= 1'b0;
         joint_count_ff <= '0;
         timeout_ff     <= TIMEOUT_RESET;
         cmd_ff         <= CMD_NOP;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (mem_we) begin
            row_valid_ff[wr_addr] <= 1'b1;
         end
         if (mem_re) begin
            rd_valid_ff <= row_valid_ff[rd_addr];
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
            rsp_last_ff  <= tick_last;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index[0])
               CSR_JOINT_COUNT:   joint_count_ff <= csr_data[COUNT_BITS-1:0];
               CSR_TIMEOUT_TICKS: timeout_ff     <= csr_data[STAMP_BITS-1:0];
               default: ;
            endcase
         end
         if (accept) begin
            cmd_ff <= cmd_type'(req_tuser[1:0]);
         end
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         joint_ff <= req_tdata[JOINT_BITS-1:0];
         kind_ff  <= req_tuser[4:2];
         value_ff <= req_tdata[JOINT_BITS +: VALUE_BITS];
         stamp_ff <= req_tdata[JOINT_BITS + VALUE_BITS +: STAMP_BITS];
      end
      if (load_out) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff && rsp_valid_ff;

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("row memory read and written in the same cycle");

   a_tick_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK_EMIT) |-> ({1'b0, idx_ff} < n_joints))
      else $error("tick joint counter beyond joints in use");

   a_last_ends_tick: assert property (@(posedge clock) disable iff (reset)
      (load_out && tick_last) |=> (state_ff == ST_IDLE && rsp_tlast))
      else $error("final joint of a tick did not end the walk");

   a_accept_only_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted word did not start row update");

endmodule

`default_nettype wire
